// ===== sv/wrs_pkg.sv =====
// Package for the weighted random selector.
// Widths, register map and defaults shared by all wrs modules. No dependencies.
`default_nettype none

package wrs_pkg;

  localparam int WORD_W              = 32;
  localparam int WEIGHT_W            = 16;
  localparam int COUNT_W             = 3;
  localparam int INDEX_W             = 3;
  localparam int REG_INDEX_W         = 3;
  localparam int DEFAULT_MAX_ENTRIES = 6;
  localparam int RESET_COUNT         = 6;
  localparam int RESET_WEIGHT        = 1;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_WEIGHT_0    = 3'd1,
    REG_WEIGHT_1    = 3'd2,
    REG_WEIGHT_2    = 3'd3,
    REG_WEIGHT_3    = 3'd4,
    REG_WEIGHT_4    = 3'd5,
    REG_WEIGHT_5    = 3'd6
  } reg_index_t;

endpackage

`default_nettype wire

// ===== sv/wrs_div_cell.sv =====
// One restoring-division step of the modulo chain: shifts in one random bit.
// Depends on wrs_pkg.
`default_nettype none

module wrs_div_cell
  import wrs_pkg::*;
#(
  parameter int REM_W = 19
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [REM_W-1:0]  total,
  input  wire logic              prev_valid,
  input  wire logic [REM_W-1:0]  prev_rem,
  input  wire logic [WORD_W-1:0] prev_dvd,
  output logic                   ready,
  output logic                   valid,
  output logic [REM_W-1:0]       rem,
  output logic [WORD_W-1:0]      dvd,
  input  wire logic              next_ready
);

  logic [REM_W:0]   trial;
  logic [REM_W-1:0] rem_next;

  assign ready = !valid || next_ready;

  always_comb begin
    trial = {prev_rem, prev_dvd[WORD_W-1]};
    if (trial >= {1'b0, total}) begin
      rem_next = REM_W'(trial - {1'b0, total});
    end else begin
      rem_next = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      rem <= rem_next;
      dvd <= {prev_dvd[WORD_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== sv/wrs_pick.sv =====
// Output stage: compares the reduced value with the weight prefix sums.
// Holds the result beat. Depends on wrs_pkg.
`default_nettype none

module wrs_pick
  import wrs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
  parameter int REM_W       = 19
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [REM_W-1:0] prefix [MAX_ENTRIES],
  input  wire logic [COUNT_W-1:0] active,
  input  wire logic [REM_W-1:0] total,
  input  wire logic             prev_valid,
  input  wire logic [REM_W-1:0] prev_rem,
  output logic                  ready,
  output logic                  out_valid,
  output logic [INDEX_W-1:0]    chosen_index,
  input  wire logic             out_stall
);

  logic [INDEX_W-1:0] pick;

  assign ready = !out_valid || !out_stall;

  always_comb begin
    pick = '0;
    if (total != '0) begin
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
        if ((COUNT_W'(i) < active) && (prev_rem < prefix[i])) begin
          pick = INDEX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      chosen_index <= pick;
    end
  end

endmodule

`default_nettype wire

// ===== sv/weighted_random_selector_unit.sv =====
// Weighted random selector top level: registers, prefix sums, modulo chain, pick.
// Depends on wrs_pkg, wrs_div_cell and wrs_pick.
//
//   channel  signals                        width  dir
//   in       in_valid/in_stall random_word  32     in
//   out      out_valid/out_stall chosen_index 3    out
//   config   wr_en wr_index wr_data         3/16   in
//
// One beat per cycle sustained while out_stall is low and no register write holds the input;
// 32 division cells, one per random bit, then the registered pick stage.
// Each cell advances when it is empty or its successor takes its beat, so
// bubbles close up while the output beat waits on out_stall.
// Reset clears all valid flags; entry_count resets to 6 and weights to 1.
// in_stall is also high for one cycle after reset and after each register write.
`default_nettype none

module weighted_random_selector_unit
  import wrs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [REG_INDEX_W-1:0] wr_index,
  input  wire logic [WEIGHT_W-1:0]    wr_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [WORD_W-1:0]      random_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [INDEX_W-1:0]          chosen_index
);

  localparam int REM_W     = $clog2(MAX_ENTRIES * ((1 << WEIGHT_W) - 1) + 1);
  localparam int NUM_CELLS = WORD_W;

  logic [COUNT_W-1:0]  entry_count;
  logic [WEIGHT_W-1:0] weight [MAX_ENTRIES];

  logic [COUNT_W-1:0]  active_next;
  logic [COUNT_W-1:0]  active;
  logic [REM_W-1:0]    prefix_next [MAX_ENTRIES];
  logic [REM_W-1:0]    prefix [MAX_ENTRIES];
  logic [REM_W-1:0]    total_next;
  logic [REM_W-1:0]    total;
  logic                cfg_wait;

  logic              cell_valid [NUM_CELLS+1];
  logic [REM_W-1:0]  cell_rem   [NUM_CELLS+1];
  logic [WORD_W-1:0] cell_dvd   [NUM_CELLS+1];
  logic              cell_ready [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_W'(RESET_COUNT);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        weight[i] <= WEIGHT_W'(RESET_WEIGHT);
      end
    end else if (wr_en) begin
      if (wr_index == REG_ENTRY_COUNT) begin
        entry_count <= wr_data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (wr_index == REG_INDEX_W'(REG_WEIGHT_0) + REG_INDEX_W'(i)) begin
          weight[i] <= wr_data;
        end
      end
    end
  end

  // prefix sums reload from the weight registers after a write; cfg_wait stalls input meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wait <= 1'b1;
    end else begin
      cfg_wait <= wr_en;
    end
  end

  always_comb begin
    active_next = (entry_count > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES) : entry_count;
    prefix_next[0] = REM_W'(weight[0]);
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      prefix_next[i] = prefix_next[i-1] + REM_W'(weight[i]);
    end
    total_next = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (active_next == COUNT_W'(i + 1)) begin
        total_next = prefix_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    active <= active_next;
    prefix <= prefix_next;
    total  <= total_next;
  end

  assign cell_valid[0] = in_valid && !cfg_wait;
  assign cell_rem[0]   = '0;
  assign cell_dvd[0]   = random_word;
  assign in_stall      = !cell_ready[1] || cfg_wait;

  for (genvar g = 1; g <= NUM_CELLS; g++) begin : g_cell
    wrs_div_cell #(
      .REM_W (REM_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .total      (total),
      .prev_valid (cell_valid[g-1]),
      .prev_rem   (cell_rem[g-1]),
      .prev_dvd   (cell_dvd[g-1]),
      .ready      (cell_ready[g]),
      .valid      (cell_valid[g]),
      .rem        (cell_rem[g]),
      .dvd        (cell_dvd[g]),
      .next_ready ((g == NUM_CELLS) ? cell_ready[0] : cell_ready[(g + 1) % (NUM_CELLS + 1)])
    );
  end

  wrs_pick #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .REM_W       (REM_W)
  ) u_pick (
    .clk          (clk),
    .rst          (rst),
    .prefix       (prefix),
    .active       (active),
    .total        (total),
    .prev_valid   (cell_valid[NUM_CELLS]),
    .prev_rem     (cell_rem[NUM_CELLS]),
    .ready        (cell_ready[0]),
    .out_valid    (out_valid),
    .chosen_index (chosen_index),
    .out_stall    (out_stall)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !cell_valid[1])
    else $error("pipeline valid after reset");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chosen_index < INDEX_W'(MAX_ENTRIES))
    else $error("chosen_index out of range");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> cell_valid[1])
    else $error("accepted beat lost at first cell");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !cell_valid[NUM_CELLS] |=> !out_valid)
    else $error("result beat repeated");
`endif

endmodule

`default_nettype wire
